// File: rtl/session_nonce_handshake_core_defines.svh
// Assertion macros shared by the session handshake RTL.
`ifndef SESSION_NONCE_HANDSHAKE_CORE_DEFINES_SVH
`define SESSION_NONCE_HANDSHAKE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SNH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SNH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/snh_pkg.sv
// Types and constants of the session handshake core.
package snh_pkg;

  localparam int NonceW = 8;

  typedef logic [NonceW-1:0] nonce_t;

  // Input function codes
  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_PKT   = 2'd1,
    FN_SEND  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  // Message kinds
  localparam logic [1:0] MT_START = 2'd0;
  localparam logic [1:0] MT_LOG   = 2'd1;

  typedef enum logic [1:0] {
    PH_RESET = 2'd0,
    PH_SENT  = 2'd1,
    PH_EST   = 2'd2
  } phase_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_PKT_START = 3'd1,
    OP_PKT_LOG   = 3'd2,
    OP_PKT_OTHER = 3'd3,
    OP_PKT_DROP  = 3'd4,
    OP_SEND      = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] mtype;
    nonce_t     snd;
    nonce_t     rcv;
  } cmd_t;

  // Swap the low three and high three bits, clear the middle two, add one, never zero
  function automatic nonce_t snh_regen(input nonce_t n);
    nonce_t r;
    r = {n[2:0], 2'b00, n[7:5]} + nonce_t'(1);
    if (r == '0) r = nonce_t'(1);
    return r;
  endfunction

endpackage

// File: rtl/snh_front.sv
// Front stage: accepts input transactions and classifies them into commands.
module snh_front
  import snh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [1:0] msg_type,
  input  nonce_t     hdr_sender_nonce,
  input  nonce_t     hdr_receiver_nonce,
  input  logic       packet_valid,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       q_full
);

  logic front_valid;
  cmd_t front_cmd;
  cmd_t cls;
  logic accept;

  always_comb begin
    cls.mtype = msg_type;
    cls.snd   = hdr_sender_nonce;
    cls.rcv   = hdr_receiver_nonce;
    case (func_t'(func))
      FN_START: cls.op = OP_START;
      FN_PKT: begin
        if (!packet_valid)          cls.op = OP_PKT_DROP;
        else if (msg_type == MT_START) cls.op = OP_PKT_START;
        else if (msg_type == MT_LOG)   cls.op = OP_PKT_LOG;
        else                        cls.op = OP_PKT_OTHER;
      end
      FN_SEND:  cls.op = OP_SEND;
      FN_CLEAR: cls.op = OP_CLEAR;
      default:  cls.op = OP_CLEAR;
    endcase
  end

  assign push     = front_valid && !q_full;
  assign in_stall = front_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push_cmd = front_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd <= cls;
    end
  end

endmodule

// File: rtl/snh_queue.sv
// Command queue between the front and back stages.
`include "session_nonce_handshake_core_defines.svh"

module snh_queue
  import snh_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == DepthCnt);
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  `SNH_ASSERT_NOW(a_no_push_full, clk, rst, push, !full, "push into full queue")
  `SNH_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, nonempty, "pop from empty queue")

endmodule

// File: rtl/snh_back.sv
// Back stage: session state update and registered result output.
`include "session_nonce_handshake_core_defines.svh"

module snh_back
  import snh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  nonce_t     cfg_wdata,
  input  logic       nonempty,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       send_header,
  output logic [1:0] send_type,
  output nonce_t     send_sender_nonce,
  output nonce_t     send_receiver_nonce,
  output logic       deliver,
  output logic [1:0] deliver_type,
  output logic       established_event,
  output logic       status,
  output logic [1:0] session_state,
  output logic       buffer_busy
);

  phase_t session_phase, session_phase_next;
  nonce_t local_nonce, local_nonce_next;
  nonce_t peer_nonce, peer_nonce_next;
  logic   receive_busy, receive_busy_next;
  logic   out_valid_next;

  nonce_t     regen_val;
  logic       id_zero, match;
  logic       do_reply, do_restart;
  logic       r_hdr, r_dlv, r_est, r_status;
  logic [1:0] r_stype, r_dtype;
  nonce_t     r_snd, r_rcv;

  assign pop = nonempty && (!out_valid || !out_stall);

  always_comb begin
    session_phase_next = session_phase;
    local_nonce_next   = local_nonce;
    peer_nonce_next    = peer_nonce;
    receive_busy_next  = receive_busy;
    regen_val  = snh_regen(local_nonce);
    id_zero    = (head.snd == '0) && (head.rcv == '0);
    match      = (head.snd == peer_nonce) && (head.rcv == local_nonce);
    do_reply   = 1'b0;
    do_restart = 1'b0;
    r_hdr      = 1'b0;
    r_stype    = '0;
    r_snd      = '0;
    r_rcv      = '0;
    r_dlv      = 1'b0;
    r_dtype    = '0;
    r_est      = 1'b0;
    r_status   = 1'b0;

    case (head.op)
      OP_START: do_restart = 1'b1;
      OP_PKT_START: begin
        receive_busy_next = 1'b0;
        if (!id_zero) begin
          case (session_phase)
            PH_RESET: begin
              if (head.snd != '0 && head.rcv == '0) begin
                do_reply           = 1'b1;
                session_phase_next = PH_EST;
              end
            end
            PH_SENT: begin
              if (head.rcv == local_nonce && head.snd != '0) begin
                peer_nonce_next    = head.snd;
                session_phase_next = PH_EST;
                r_est              = 1'b1;
              end else if (head.rcv == '0) begin
                if (head.snd == local_nonce) begin
                  do_restart = 1'b1;
                end else if (head.snd < local_nonce) begin
                  do_reply           = 1'b1;
                  session_phase_next = PH_EST;
                end
              end
            end
            PH_EST: begin
              if (head.snd != '0 && head.rcv == '0) do_reply = 1'b1;
              else session_phase_next = PH_RESET;
            end
            default: session_phase_next = PH_RESET;
          endcase
        end
      end
      OP_PKT_LOG: begin
        receive_busy_next = 1'b1;
        if (id_zero || match) begin
          r_dlv   = 1'b1;
          r_dtype = head.mtype;
        end
      end
      OP_PKT_OTHER: begin
        receive_busy_next = 1'b1;
        if (session_phase == PH_EST && match) begin
          r_dlv   = 1'b1;
          r_dtype = head.mtype;
        end
      end
      OP_SEND: begin
        if (session_phase != PH_EST && head.mtype != MT_LOG) begin
          r_status = 1'b1;
        end else begin
          r_hdr   = 1'b1;
          r_stype = head.mtype;
          // unestablished log goes out with a zero session id
          if (session_phase == PH_EST) begin
            r_snd = local_nonce;
            r_rcv = peer_nonce;
          end
        end
      end
      OP_CLEAR: receive_busy_next = 1'b0;
      OP_PKT_DROP: ;
      default: ;
    endcase

    if (do_restart) begin
      local_nonce_next   = regen_val;
      peer_nonce_next    = '0;
      session_phase_next = PH_SENT;
      r_hdr              = 1'b1;
      r_stype            = MT_START;
      r_snd              = regen_val;
      r_rcv              = '0;
    end
    if (do_reply) begin
      local_nonce_next = regen_val;
      peer_nonce_next  = head.snd;
      r_hdr            = 1'b1;
      r_stype          = MT_START;
      r_snd            = regen_val;
      r_rcv            = head.snd;
      r_est            = 1'b1;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (pop)            out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_phase <= PH_RESET;
      local_nonce   <= '0;
      peer_nonce    <= '0;
      receive_busy  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (cfg_wen) begin
        local_nonce <= cfg_wdata;
      end else if (pop) begin
        local_nonce <= local_nonce_next;
      end
      if (pop) begin
        session_phase <= session_phase_next;
        peer_nonce    <= peer_nonce_next;
        receive_busy  <= receive_busy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      send_header         <= r_hdr;
      send_type           <= r_stype;
      send_sender_nonce   <= r_snd;
      send_receiver_nonce <= r_rcv;
      deliver             <= r_dlv;
      deliver_type        <= r_dtype;
      established_event   <= r_est;
      status              <= r_status;
      session_state       <= session_phase_next;
      buffer_busy         <= receive_busy_next;
    end
  end

  `SNH_ASSERT_NOW(a_est_phase, clk, rst, out_valid && established_event,
                  session_state == PH_EST, "established event outside established phase")
  `SNH_ASSERT_NEXT(a_clear_idle, clk, rst, pop && head.op == OP_CLEAR,
                   out_valid && !buffer_busy, "buffer clear left busy set")

endmodule

// File: rtl/session_nonce_handshake_core.sv
// Top level of the session nonce handshake core.
// One transaction per cycle is sustained while out_stall stays low. A transaction passes
// through the front register, which holds its classified command, a command queue of
// QUEUE_DEPTH entries that absorbs output stalls, and the back stage, which updates the
// session state and result register together. in_stall rises only when the front
// register is full and the queue cannot take its command. A write on cfg_wen loads
// the local nonce directly; write only while no transaction is in flight.
module session_nonce_handshake_core
  import snh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [1:0] msg_type,
  input  logic [7:0] hdr_sender_nonce,
  input  logic [7:0] hdr_receiver_nonce,
  input  logic       packet_valid,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       send_header,
  output logic [1:0] send_type,
  output logic [7:0] send_sender_nonce,
  output logic [7:0] send_receiver_nonce,
  output logic       deliver,
  output logic [1:0] deliver_type,
  output logic       established_event,
  output logic       status,
  output logic [1:0] session_state,
  output logic       buffer_busy
);

  logic push, q_full, pop, nonempty;
  cmd_t push_cmd, head;

  snh_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .msg_type           (msg_type),
    .hdr_sender_nonce   (hdr_sender_nonce),
    .hdr_receiver_nonce (hdr_receiver_nonce),
    .packet_valid       (packet_valid),
    .push               (push),
    .push_cmd           (push_cmd),
    .q_full             (q_full)
  );

  snh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  snh_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wen             (cfg_wen),
    .cfg_wdata           (cfg_wdata),
    .nonempty            (nonempty),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .send_header         (send_header),
    .send_type           (send_type),
    .send_sender_nonce   (send_sender_nonce),
    .send_receiver_nonce (send_receiver_nonce),
    .deliver             (deliver),
    .deliver_type        (deliver_type),
    .established_event   (established_event),
    .status              (status),
    .session_state       (session_state),
    .buffer_busy         (buffer_busy)
  );

endmodule

// File: test/session_handshake_checker.sv
`timescale 1ns / 100ps
// Checker for the session handshake core: predicts each transaction's result and compares.
module session_handshake_checker
  import snh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] func,
  input  logic [1:0] msg_type,
  input  logic [7:0] hdr_sender_nonce,
  input  logic [7:0] hdr_receiver_nonce,
  input  logic       packet_valid,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       send_header,
  input  logic [1:0] send_type,
  input  logic [7:0] send_sender_nonce,
  input  logic [7:0] send_receiver_nonce,
  input  logic       deliver,
  input  logic [1:0] deliver_type,
  input  logic       established_event,
  input  logic       status,
  input  logic [1:0] session_state,
  input  logic       buffer_busy,
  output int         fail_count,
  output int         outstanding,
  output phase_t     cur_phase,
  output nonce_t     cur_local,
  output nonce_t     cur_remote
);

  typedef struct packed {
    logic       send_header;
    logic [1:0] send_type;
    nonce_t     send_snd;
    nonce_t     send_rcv;
    logic       deliver;
    logic [1:0] deliver_type;
    logic       established;
    logic       status;
    logic [1:0] state;
    logic       busy;
  } session_result_t;

  session_result_t expected_results[$];

  phase_t sess_phase;
  nonce_t own_nonce;
  nonce_t peer_nonce;
  logic   rx_busy;
  int     fails = 0;
  int     pending = 0;

  assign fail_count  = fails;
  assign outstanding = pending;
  assign cur_phase   = sess_phase;
  assign cur_local   = own_nonce;
  assign cur_remote  = peer_nonce;

  // Low three bits move to the top, top three to the bottom, middle cleared; skip zero
  function automatic nonce_t next_nonce(input nonce_t n);
    nonce_t r;
    r = {n[2:0], 5'b00000} | {5'b00000, n[7:5]};
    r = r + 8'd1;
    if (r == '0) r = 8'd1;
    return r;
  endfunction

  task automatic announce_start(inout session_result_t r);
    r.send_header = 1'b1;
    r.send_type   = MT_START;
    r.send_snd    = own_nonce;
    r.send_rcv    = peer_nonce;
  endtask

  task automatic open_session(inout session_result_t r);
    own_nonce  = next_nonce(own_nonce);
    peer_nonce = '0;
    announce_start(r);
    sess_phase = PH_SENT;
  endtask

  task automatic answer_peer(input nonce_t snd, inout session_result_t r);
    own_nonce  = next_nonce(own_nonce);
    peer_nonce = snd;
    announce_start(r);
  endtask

  task automatic handle_peer_start(input nonce_t snd, input nonce_t rcv,
                                   inout session_result_t r);
    if (snd != '0 || rcv != '0) begin
      case (sess_phase)
        PH_RESET: begin
          if (snd != '0 && rcv == '0) begin
            answer_peer(snd, r);
            sess_phase    = PH_EST;
            r.established = 1'b1;
          end
        end
        PH_SENT: begin
          if (rcv == own_nonce && snd != '0) begin
            peer_nonce    = snd;
            sess_phase    = PH_EST;
            r.established = 1'b1;
          end else if (rcv == '0) begin
            // equal nonces: retry with a fresh one; lower nonce wins otherwise
            if (snd == own_nonce) begin
              open_session(r);
            end else if (snd < own_nonce) begin
              answer_peer(snd, r);
              sess_phase    = PH_EST;
              r.established = 1'b1;
            end
          end
        end
        PH_EST: begin
          if (snd != '0 && rcv == '0) begin
            answer_peer(snd, r);
            r.established = 1'b1;
          end else begin
            sess_phase = PH_RESET;
          end
        end
        default: sess_phase = PH_RESET;
      endcase
    end
  endtask

  task automatic predict_session_result(input func_t fn, input logic [1:0] mtype,
                                        input nonce_t snd, input nonce_t rcv,
                                        input logic pkt_ok, output session_result_t r);
    logic id_match;
    r = '0;
    case (fn)
      FN_START: open_session(r);
      FN_PKT: begin
        if (pkt_ok) begin
          rx_busy  = 1'b1;
          id_match = (snd == peer_nonce) && (rcv == own_nonce);
          if (mtype == MT_START) begin
            handle_peer_start(snd, rcv, r);
            rx_busy = 1'b0;
          end else if (mtype == MT_LOG) begin
            // log messages pass with the zero session id too
            if ((snd == '0 && rcv == '0) || id_match) begin
              r.deliver      = 1'b1;
              r.deliver_type = mtype;
            end
          end else if (sess_phase == PH_EST && id_match) begin
            r.deliver      = 1'b1;
            r.deliver_type = mtype;
          end
        end
      end
      FN_SEND: begin
        if (sess_phase != PH_EST && mtype != MT_LOG) begin
          r.status = 1'b1;
        end else begin
          r.send_header = 1'b1;
          r.send_type   = mtype;
          if (sess_phase == PH_EST) begin
            r.send_snd = own_nonce;
            r.send_rcv = peer_nonce;
          end
        end
      end
      default: rx_busy = 1'b0;
    endcase
    r.state = sess_phase;
    r.busy  = rx_busy;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic compare_results(input session_result_t want, input session_result_t got);
    check_field("send_header", want.send_header, got.send_header);
    check_field("send_type", want.send_type, got.send_type);
    check_field("send_sender_nonce", want.send_snd, got.send_snd);
    check_field("send_receiver_nonce", want.send_rcv, got.send_rcv);
    check_field("deliver", want.deliver, got.deliver);
    check_field("deliver_type", want.deliver_type, got.deliver_type);
    check_field("established_event", want.established, got.established);
    check_field("status", want.status, got.status);
    check_field("session_state", want.state, got.state);
    check_field("buffer_busy", want.busy, got.busy);
  endtask

  // Sample mid-cycle: inputs only move at the rising edge, so this sees what the edge will take
  always @(negedge clk) begin : watch
    session_result_t got;
    session_result_t want;
    if (rst) begin
      sess_phase = PH_RESET;
      own_nonce  = '0;
      peer_nonce = '0;
      rx_busy    = 1'b0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{send_header, send_type, send_sender_nonce, send_receiver_nonce, deliver,
                deliver_type, established_event, status, session_state, buffer_busy};
        if (expected_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fails++;
        end else begin
          want = expected_results.pop_front();
          compare_results(want, got);
        end
      end
      if (cfg_wen) begin
        own_nonce = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        predict_session_result(func_t'(func), msg_type, hdr_sender_nonce,
                               hdr_receiver_nonce, packet_valid, want);
        expected_results.push_back(want);
      end
      pending = expected_results.size();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench top: stimulus, stall patterns and verdict for the session handshake core.
module tb;
  import snh_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 12;

  localparam logic [1:0] MT_OTHER = 2'd2;
  localparam logic [1:0] MT_SPARE = 2'd3;

  typedef struct {
    func_t      fn;
    logic [1:0] mtype;
    nonce_t     snd;
    nonce_t     rcv;
    logic       pkt_ok;
  } session_event_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wen;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] func;
  logic [1:0] msg_type;
  logic [7:0] hdr_sender_nonce;
  logic [7:0] hdr_receiver_nonce;
  logic       packet_valid;
  logic       out_valid;
  logic       out_stall;
  logic       send_header;
  logic [1:0] send_type;
  logic [7:0] send_sender_nonce;
  logic [7:0] send_receiver_nonce;
  logic       deliver;
  logic [1:0] deliver_type;
  logic       established_event;
  logic       status;
  logic [1:0] session_state;
  logic       buffer_busy;

  int     fail_count;
  int     outstanding;
  phase_t cur_phase;
  nonce_t cur_local;
  nonce_t cur_remote;

  int cycle_count = 0;
  bit tx_idling   = 1'b1;
  bit rx_idling   = 1'b1;
  bit hold_output = 1'b0;

  always #4 clk = ~clk;

  session_nonce_handshake_core uut (
    .clk                (clk),
    .rst                (rst),
    .cfg_wen            (cfg_wen),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .msg_type           (msg_type),
    .hdr_sender_nonce   (hdr_sender_nonce),
    .hdr_receiver_nonce (hdr_receiver_nonce),
    .packet_valid       (packet_valid),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .send_header        (send_header),
    .send_type          (send_type),
    .send_sender_nonce  (send_sender_nonce),
    .send_receiver_nonce(send_receiver_nonce),
    .deliver            (deliver),
    .deliver_type       (deliver_type),
    .established_event  (established_event),
    .status             (status),
    .session_state      (session_state),
    .buffer_busy        (buffer_busy)
  );

  session_handshake_checker chk (
    .clk                (clk),
    .rst                (rst),
    .cfg_wen            (cfg_wen),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .msg_type           (msg_type),
    .hdr_sender_nonce   (hdr_sender_nonce),
    .hdr_receiver_nonce (hdr_receiver_nonce),
    .packet_valid       (packet_valid),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .send_header        (send_header),
    .send_type          (send_type),
    .send_sender_nonce  (send_sender_nonce),
    .send_receiver_nonce(send_receiver_nonce),
    .deliver            (deliver),
    .deliver_type       (deliver_type),
    .established_event  (established_event),
    .status             (status),
    .session_state      (session_state),
    .buffer_busy        (buffer_busy),
    .fail_count         (fail_count),
    .outstanding        (outstanding),
    .cur_phase          (cur_phase),
    .cur_local          (cur_local),
    .cur_remote         (cur_remote)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_output = 1'b0;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic session_event_t ev_of(input func_t fn, input logic [1:0] mtype,
                                           input nonce_t snd, input nonce_t rcv,
                                           input logic pkt_ok);
    session_event_t ev;
    ev.fn     = fn;
    ev.mtype  = mtype;
    ev.snd    = snd;
    ev.rcv    = rcv;
    ev.pkt_ok = pkt_ok;
    return ev;
  endfunction

  // A mix of handshake and data traffic, part of it built on the current session ids, and some noise
  function automatic session_event_t random_event();
    session_event_t ev;
    int pick;
    ev = ev_of(FN_PKT, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'b1);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      ev.fn = FN_START;
    end else if (pick < 18) begin
      ev.fn = FN_SEND;
    end else if (pick < 22) begin
      ev.fn = FN_CLEAR;
    end else if (pick < 27) begin
      ev.pkt_ok = 1'b0;
    end else if (pick < 32) begin
      // random header, left as drawn
    end else if (pick < 44) begin
      ev.mtype = MT_START;
      ev.snd   = 8'($urandom_range(1, 255));
      ev.rcv   = '0;
    end else if (pick < 52) begin
      ev.mtype = MT_START;
      ev.snd   = 8'($urandom_range(1, 255));
      ev.rcv   = cur_local;
    end else if (pick < 55) begin
      ev.mtype = MT_START;
      ev.snd   = cur_local;
      ev.rcv   = '0;
    end else if (pick < 58) begin
      ev.mtype = MT_START;
      ev.snd   = '0;
      ev.rcv   = '0;
    end else if (pick < 62) begin
      ev.mtype = MT_LOG;
      ev.snd   = '0;
      ev.rcv   = '0;
    end else if (pick < 90) begin
      ev.mtype = 2'($urandom_range(1, 3));
      ev.snd   = cur_remote;
      ev.rcv   = cur_local;
    end else begin
      ev.mtype = MT_START;
      ev.rcv   = 8'($urandom_range(1, 255));
    end
    return ev;
  endfunction

  // Present one transaction and hold it until taken, then maybe idle a while
  task automatic offer(input session_event_t ev);
    logic held;
    in_valid           <= 1'b1;
    func               <= ev.fn;
    msg_type           <= ev.mtype;
    hdr_sender_nonce   <= ev.snd;
    hdr_receiver_nonce <= ev.rcv;
    packet_valid       <= ev.pkt_ok;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    if (tx_idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic offer_random(input int count);
    repeat (count) offer(random_event());
  endtask

  // Stop sending and let every predicted result come back
  task automatic settle();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input nonce_t value);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_wen            <= 1'b0;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    func               <= FN_START;
    msg_type           <= MT_START;
    hdr_sender_nonce   <= '0;
    hdr_receiver_nonce <= '0;
    packet_valid       <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: local nonce starts at zero out of reset
    offer(ev_of(FN_SEND, MT_OTHER, '0, '0, 1'b1));
    offer(ev_of(FN_SEND, MT_START, '0, '0, 1'b1));
    offer(ev_of(FN_SEND, MT_LOG, 8'hFF, 8'hFF, 1'b1));
    offer(ev_of(FN_PKT, MT_LOG, 8'hFF, 8'hFF, 1'b0));
    offer(ev_of(FN_PKT, MT_LOG, '0, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_OTHER, '0, '0, 1'b1));
    offer(ev_of(FN_CLEAR, MT_OTHER, '0, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_SPARE, 8'hFF, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_START, '0, '0, 1'b1));
    offer(ev_of(FN_START, MT_START, '0, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_START, cur_local, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_START, 8'hFF, cur_local, 1'b1));
    offer(ev_of(FN_SEND, MT_OTHER, '0, '0, 1'b1));
    offer(ev_of(FN_SEND, MT_SPARE, '0, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_OTHER, cur_remote, cur_local, 1'b1));
    offer(ev_of(FN_PKT, MT_SPARE, cur_remote, cur_local, 1'b1));
    offer(ev_of(FN_PKT, MT_LOG, cur_remote, cur_local, 1'b1));
    offer(ev_of(FN_PKT, MT_LOG, 8'h5A, 8'hA5, 1'b1));
    offer(ev_of(FN_PKT, MT_START, 8'h01, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_START, 8'h05, 8'h07, 1'b1));
    offer(ev_of(FN_PKT, MT_START, 8'hFF, '0, 1'b1));
    offer(ev_of(FN_START, MT_LOG, '0, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_START, 8'h01, '0, 1'b1));
    offer(ev_of(FN_START, MT_START, '0, '0, 1'b1));
    offer(ev_of(FN_PKT, MT_START, 8'hFF, '0, 1'b1));
    offer(ev_of(FN_CLEAR, MT_LOG, '0, '0, 1'b1));

    write_seed(8'hFF);
    offer_random(350);

    // Long output hold while input keeps coming: fill the core until it stalls
    write_seed(8'h00);
    offer_random(150);
    hold_output = 1'b1;
    offer_random(200);

    // Pause the input until the core has drained completely
    write_seed(nonce_t'($urandom));
    offer_random(150);
    settle();
    offer_random(200);

    write_seed(8'h01);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    offer_random(150);
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    offer_random(200);

    // Final stretch at full rate on both sides
    write_seed(8'h80);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    offer_random(450);

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
